// ----- rtl/slcd_pkg.sv -----
package slcd_pkg;

  typedef enum logic [2:0] {
    ACT_DIGIT   = 3'd0,
    ACT_LETTER  = 3'd1,
    ACT_SYMBOL  = 3'd2,
    ACT_REDRAW  = 3'd3,
    ACT_COMMAND = 3'd4,
    ACT_CLEAR   = 3'd5
  } action_e;

  typedef struct packed {
    logic [2:0] action;
    logic [2:0] position;
    logic [7:0] value;
  } req_t;

  typedef struct packed {
    logic [7:0] shift_bits;
    logic [3:0] shift_count;
    logic       lsb_first;
    logic       frame_end;
  } rsp_t;

  localparam int unsigned TABLE_LETTERS = 20;
  localparam int unsigned LETTER_IDX_W  = $clog2(TABLE_LETTERS);
  localparam int unsigned DIGITS        = 10;

  typedef struct packed {
    logic                    done;
    logic                    hit;
    logic [LETTER_IDX_W-1:0] index;
  } scan_t;

  localparam logic [7:0] BLANK_CODE  = 8'hFF;
  localparam logic [7:0] SYM_LOW     = 8'h08;
  localparam logic [7:0] SYM_HIGH    = 8'h80;

  localparam logic [7:0] HEAD_CODE   = 8'h05;
  localparam logic [3:0] HEAD_LEN    = 4'd3;
  localparam logic [7:0] ADDR_CODE   = 8'h00;
  localparam logic [3:0] ADDR_LEN    = 4'd6;
  localparam logic [7:0] CMD_CODE    = 8'h08;
  localparam logic [3:0] CMD_CODE_LEN = 4'd4;
  localparam logic [3:0] CMD_LEN     = 4'd8;

  localparam logic [7:0] DIGIT_LOW [DIGITS] = '{
    8'hF5, 8'h60, 8'hD3, 8'hF2, 8'h66, 8'hB6, 8'hB7, 8'hE0, 8'hF7, 8'hF6};
  localparam logic [7:0] DIGIT_HIGH [DIGITS] = '{
    8'h5F, 8'h06, 8'h6B, 8'h2F, 8'h36, 8'h3D, 8'h7D, 8'h07, 8'h7F, 8'h3F};

  localparam logic [7:0] LETTER_CODE [TABLE_LETTERS] = '{
    8'h41, 8'h43, 8'h45, 8'h46, 8'h48, 8'h4A, 8'h4C, 8'h4F, 8'h50, 8'h53,
    8'h55, 8'h62, 8'h63, 8'h64, 8'h68, 8'h69, 8'h6E, 8'h6F, 8'h72, 8'h75};
  localparam logic [7:0] LETTER_LOW [TABLE_LETTERS] = '{
    8'hE7, 8'h95, 8'h97, 8'h87, 8'h67, 8'h70, 8'h15, 8'hF5, 8'hC7, 8'hB6,
    8'h75, 8'h37, 8'h13, 8'h73, 8'h27, 8'h01, 8'h23, 8'h33, 8'h03, 8'h31};
  localparam logic [7:0] LETTER_HIGH [TABLE_LETTERS] = '{
    8'h77, 8'h59, 8'h79, 8'h71, 8'h76, 8'h0E, 8'h58, 8'h5F, 8'h73, 8'h3D,
    8'h5E, 8'h7C, 8'h68, 8'h6E, 8'h74, 8'h40, 8'h64, 8'h6C, 8'h60, 8'h4C};

endpackage

// ----- rtl/slcd_req_if.sv -----
interface slcd_req_if;
  logic             valid;
  logic             ready;
  slcd_pkg::req_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/slcd_rsp_if.sv -----
interface slcd_rsp_if;
  logic             valid;
  logic             ready;
  slcd_pkg::rsp_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/slcd_letter_scan.sv -----
module slcd_letter_scan #(
  parameter int unsigned LETTER_COUNT = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [7:0]          code_i,
  output slcd_pkg::scan_t     res_o
);
  import slcd_pkg::*;

  localparam int unsigned LIMIT =
    (LETTER_COUNT < TABLE_LETTERS) ? LETTER_COUNT : TABLE_LETTERS;
  localparam logic [LETTER_IDX_W-1:0] LAST_IDX = LETTER_IDX_W'(LIMIT - 1);

  logic                    busy_q;
  logic                    done_q;
  logic                    hit_q;
  logic [LETTER_IDX_W-1:0] idx_q;
  logic [7:0]              code_q;
  logic                    match;

  assign match = (LETTER_CODE[idx_q] == code_q);
  assign res_o = '{done: done_q, hit: hit_q, index: idx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      hit_q  <= 1'b0;
      idx_q  <= '0;
      code_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      hit_q  <= 1'b0;
      idx_q  <= '0;
      code_q <= code_i;
    end else if (busy_q) begin
      priority if (match) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
        hit_q  <= 1'b1;
      end else if (idx_q == LAST_IDX) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        idx_q <= idx_q + LETTER_IDX_W'(1);
      end
    end else begin
      done_q <= 1'b0;
    end
  end

endmodule

// ----- rtl/segment_lcd_buffer_and_serial_writer.sv -----
// Channel  Dir  Payload                                         Handshake
// req_i    in   action, position, value                         valid/ready
// rsp_o    out  shift_bits, shift_count, lsb_first, frame_end   valid/ready
//
// One request at a time. Digit and symbol writes go through the update state; a
// non-blank letter write first runs the single-comparator table scan before it.
// Redraw and clear give POSITIONS+2 segments, command gives 2, one per cycle
// while the sink takes them; a full output register stalls the emitter.
// Reset clears the segment RAM and all control state at once.
module segment_lcd_buffer_and_serial_writer #(
  parameter int unsigned POSITIONS    = 8,
  parameter int unsigned ENTRY_BITS   = 8,
  parameter int unsigned LETTER_COUNT = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  slcd_req_if.sink    req_i,
  slcd_rsp_if.source  rsp_o
);
  import slcd_pkg::*;

  localparam int unsigned AW    = $clog2(POSITIONS);
  localparam int unsigned SEG_W = $clog2(POSITIONS + 2);
  localparam logic [SEG_W-1:0] LAST_SEG   = SEG_W'(POSITIONS + 1);
  localparam logic [SEG_W-1:0] FIRST_ENT  = SEG_W'(2);
  localparam logic [7:0]       ENTRY_MASK = 8'((16'd1 << ENTRY_BITS) - 16'd1);
  localparam logic [3:0]       ENTRY_LEN  = 4'(ENTRY_BITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_EMIT
  } state_e;

  state_e           state_q;
  logic [2:0]       act_q;
  logic [2:0]       pos_q;
  logic [7:0]       val_q;
  logic [SEG_W-1:0] seg_q;
  logic [7:0]       ram_q [POSITIONS];
  logic             out_valid_q;
  rsp_t             out_q;

  logic             accept;
  logic             pos_ok;
  logic             scan_start;
  scan_t            scan;
  logic [AW-1:0]    pos_idx;
  logic [AW-1:0]    ent_idx;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       rd_data;
  logic [7:0]       sym;
  logic [7:0]       keep;
  logic [7:0]       new_entry;
  logic             can_load;
  logic             load;
  logic             last_seg;
  rsp_t             seg_out;

  assign req_i.ready   = (state_q == ST_IDLE);
  assign accept        = req_i.valid && req_i.ready;
  assign pos_ok        = int'(req_i.payload.position) < POSITIONS;
  assign scan_start    = accept && pos_ok && (req_i.payload.action == ACT_LETTER)
                         && (req_i.payload.value != BLANK_CODE);

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;
  assign can_load      = !out_valid_q || rsp_o.ready;
  assign load          = (state_q == ST_EMIT) && can_load;

  assign pos_idx = AW'(pos_q);
  assign ent_idx = AW'(seg_q - FIRST_ENT);
  assign rd_addr = (state_q == ST_EMIT) ? ent_idx : pos_idx;
  assign rd_data = ram_q[rd_addr];

  slcd_letter_scan #(
    .LETTER_COUNT (LETTER_COUNT)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .code_i  (req_i.payload.value),
    .res_o   (scan)
  );

  always_comb begin
    sym       = pos_q[2] ? SYM_HIGH : SYM_LOW;
    keep      = rd_data & sym;
    new_entry = rd_data;
    unique case (act_q)
      ACT_DIGIT: begin
        if (val_q < 8'(DIGITS)) begin
          new_entry = (pos_q[2] ? DIGIT_HIGH[val_q[3:0]] : DIGIT_LOW[val_q[3:0]]) | keep;
        end else begin
          new_entry = keep;
        end
      end
      ACT_LETTER: begin
        priority if (val_q == BLANK_CODE) begin
          new_entry = keep;
        end else if (scan.hit) begin
          new_entry = (pos_q[2] ? LETTER_HIGH[scan.index] : LETTER_LOW[scan.index]) | keep;
        end else begin
          new_entry = rd_data;
        end
      end
      ACT_SYMBOL: begin
        new_entry = (val_q != 8'd0) ? (rd_data | sym) : (rd_data & ~sym);
      end
      default: new_entry = rd_data;
    endcase
  end

  always_comb begin
    if (act_q == ACT_COMMAND) begin
      last_seg = (seg_q == SEG_W'(1));
      if (seg_q == '0) begin
        seg_out = '{shift_bits: CMD_CODE, shift_count: CMD_CODE_LEN,
                    lsb_first: 1'b0, frame_end: 1'b0};
      end else begin
        seg_out = '{shift_bits: val_q, shift_count: CMD_LEN,
                    lsb_first: 1'b0, frame_end: 1'b1};
      end
    end else begin
      last_seg = (seg_q == LAST_SEG);
      priority if (seg_q == '0) begin
        seg_out = '{shift_bits: HEAD_CODE, shift_count: HEAD_LEN,
                    lsb_first: 1'b0, frame_end: 1'b0};
      end else if (seg_q == SEG_W'(1)) begin
        seg_out = '{shift_bits: ADDR_CODE, shift_count: ADDR_LEN,
                    lsb_first: 1'b0, frame_end: 1'b0};
      end else begin
        seg_out = '{shift_bits: rd_data & ENTRY_MASK, shift_count: ENTRY_LEN,
                    lsb_first: 1'b1, frame_end: last_seg};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      act_q       <= '0;
      pos_q       <= '0;
      val_q       <= '0;
      seg_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int i = 0; i < POSITIONS; i++) begin
        ram_q[i] <= '0;
      end
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            act_q <= req_i.payload.action;
            pos_q <= req_i.payload.position;
            val_q <= req_i.payload.value;
            seg_q <= '0;
            unique case (req_i.payload.action)
              ACT_DIGIT, ACT_SYMBOL: begin
                if (pos_ok) state_q <= ST_UPDATE;
              end
              ACT_LETTER: begin
                if (pos_ok) begin
                  state_q <= scan_start ? ST_SCAN : ST_UPDATE;
                end
              end
              ACT_REDRAW, ACT_COMMAND: state_q <= ST_EMIT;
              ACT_CLEAR: begin
                for (int i = 0; i < POSITIONS; i++) begin
                  ram_q[i] <= '0;
                end
                state_q <= ST_EMIT;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_SCAN: begin
          if (scan.done) state_q <= ST_UPDATE;
        end
        ST_UPDATE: begin
          ram_q[pos_idx] <= new_entry;
          state_q        <= ST_IDLE;
        end
        ST_EMIT: begin
          if (can_load) begin
            out_q <= seg_out;
            if (last_seg) begin
              state_q <= ST_IDLE;
            end else begin
              seg_q <= seg_q + SEG_W'(1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
